/* src/apr_pkg.sv */
// ----------------------------------------------------------------------------
// apr_pkg: shared types and constants of the aligned range splitter
// Field widths, default address width, queue depth and the queued-range type.
// ----------------------------------------------------------------------------
package apr_pkg;

   // Fixed payload widths of the channels
   localparam int FIELD_W  = 32;
   localparam int PREFIX_W = 6;

   // Default address width (2 to 32)
   localparam int ADDR_WIDTH_DEF = 32;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // One range waiting for the splitter engine
   typedef struct packed {
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] length;
   } range_type;

endpackage

/* src/apr_if.sv */
// ----------------------------------------------------------------------------
// apr_req_if / apr_rsp_if: valid/ready channels of the range splitter
// Request carries one range; response carries one aligned block.
// ----------------------------------------------------------------------------
interface apr_req_if
   import apr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  range_start;
   logic [FIELD_W-1:0]  range_length;

   modport source (output valid, range_start, range_length, input ready);
   modport sink   (input valid, range_start, range_length, output ready);
endinterface

interface apr_rsp_if
   import apr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  block_start;
   logic [PREFIX_W-1:0] prefix_length;
   logic                is_last;

   modport source (output valid, block_start, prefix_length, is_last, input ready);
   modport sink   (input valid, block_start, prefix_length, is_last, output ready);
endinterface

/* src/aligned_pow2_range_splitter.sv */
// A request is written to the queue, loaded into the engine range registers
//   and split into the response stage, one block per cycle while rsp is ready;
//   the next range loads only after the last block of the current one, and a
//   range yields at most 2*ADDR_WIDTH-1 blocks (63 at 32 bits).
// Reset: synchronous, clears queue pointers and valid flags; no clearing pass.
// ----------------------------------------------------------------------------
// aligned_pow2_range_splitter: split an address range into aligned blocks
// Intake and queue decouple request transfers from the block generator.
// ----------------------------------------------------------------------------
module aligned_pow2_range_splitter
   import apr_pkg::*;
#(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   apr_req_if.sink    req_if,
   apr_rsp_if.source  rsp_if
);

   logic       q_full;
   logic       q_push;
   logic       q_pop;
   logic       q_not_empty;
   range_type  q_in;
   range_type  q_head;

   apr_front #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_front (
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_in)
   );

   apr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   apr_engine #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_if      (rsp_if)
   );

endmodule

/* src/apr_front.sv */
// ----------------------------------------------------------------------------
// apr_front: request intake
// Masks the range to the address width, drops empty ranges and pushes the
// rest into the queue.
// ----------------------------------------------------------------------------
module apr_front
   import apr_pkg::*;
#(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
   apr_req_if.sink    req_if,
   input  logic       q_full,
   output logic       q_push,
   output range_type  q_data
);

   localparam logic [FIELD_W-1:0] ADDR_MASK =
      FIELD_W'((64'd1 << ADDR_WIDTH) - 64'd1);

   // Accept whenever the queue has room; empty ranges are consumed silently
   always_comb begin
      req_if.ready  = !q_full;
      q_data.start  = req_if.range_start & ADDR_MASK;
      q_data.length = req_if.range_length & ADDR_MASK;
      q_push        = req_if.valid && !q_full && (q_data.length != '0);
   end

endmodule

/* src/apr_queue.sv */
// ----------------------------------------------------------------------------
// apr_queue: short FIFO between intake and splitter engine
// Lets the intake keep taking ranges while the engine works on a long one.
// ----------------------------------------------------------------------------
module apr_queue
   import apr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  range_type  push_data,
   input  logic       pop,
   output logic       full,
   output logic       not_empty,
   output range_type  head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   range_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/apr_engine.sv */
// ----------------------------------------------------------------------------
// apr_engine: aligned block generator
// Emits one aligned power-of-two block per cycle from the current range
// into a registered response stage, while that stage is free or being taken.
// ----------------------------------------------------------------------------
module apr_engine
   import apr_pkg::*;
#(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_not_empty,
   input  range_type  q_head,
   output logic       q_pop,
   apr_rsp_if.source  rsp_if
);

   localparam int IDX_W = (ADDR_WIDTH > 1) ? $clog2(ADDR_WIDTH) : 1;

   logic                   busy_ff, busy_in;
   logic [ADDR_WIDTH-1:0]  start_ff, start_in;
   logic [ADDR_WIDTH-1:0]  rem_ff, rem_in;
   logic                   out_valid_ff, out_valid_in;
   logic [ADDR_WIDTH-1:0]  out_start_ff;
   logic [PREFIX_W-1:0]    out_prefix_ff;
   logic                   out_last_ff;

   logic [IDX_W-1:0]       top_idx;
   logic [IDX_W-1:0]       low_idx;
   logic [IDX_W-1:0]       pow;
   logic [ADDR_WIDTH-1:0]  size;
   logic [ADDR_WIDTH-1:0]  rem_next;
   logic                   step;
   logic                   load;

   // Highest set bit of the remaining length, lowest set bit of the start
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < ADDR_WIDTH; i++) begin
         if (rem_ff[i]) begin
            top_idx = IDX_W'(i);
         end
      end
      low_idx = '0;
      for (int i = ADDR_WIDTH - 1; i >= 0; i--) begin
         if (start_ff[i]) begin
            low_idx = IDX_W'(i);
         end
      end
   end

   // Block size: smaller of alignment and length bound (zero start is fully aligned)
   always_comb begin
      pow      = ((start_ff == '0) || (top_idx < low_idx)) ? top_idx : low_idx;
      size     = {{(ADDR_WIDTH-1){1'b0}}, 1'b1} << pow;
      rem_next = rem_ff - size;
   end

   // Control: step when output stage is free, load next range when idle
   always_comb begin
      step    = busy_ff && (!out_valid_ff || rsp_if.ready);
      load    = !busy_ff && q_not_empty;
      q_pop   = load;
      busy_in = busy_ff;
      start_in = start_ff;
      rem_in   = rem_ff;
      if (load) begin
         busy_in  = 1'b1;
         start_in = q_head.start[ADDR_WIDTH-1:0];
         rem_in   = q_head.length[ADDR_WIDTH-1:0];
      end else if (step) begin
         busy_in  = (rem_next != '0);
         start_in = start_ff + size;
         rem_in   = rem_next;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Range and response payload registers
   always_ff @(posedge clock) begin
      start_ff <= start_in;
      rem_ff   <= rem_in;
      if (step) begin
         out_start_ff  <= start_ff;
         out_prefix_ff <= PREFIX_W'(ADDR_WIDTH) - PREFIX_W'(pow);
         out_last_ff   <= (rem_next == '0);
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.block_start   = FIELD_W'(out_start_ff);
   assign rsp_if.prefix_length = out_prefix_ff;
   assign rsp_if.is_last       = out_last_ff;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of aligned_pow2_range_splitter
// Drives ranges into the splitter, predicts the aligned power-of-two blocks
// of each one in a scoreboard class and checks every block transfer in order.
// Directed corner ranges come first, then random ranges under four idle and
// stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb
   import apr_pkg::*;
;

   localparam int ADDR_W       = ADDR_WIDTH_DEF;
   localparam int MAX_BLOCKS   = 63;
   localparam int RANDOM_RANGES = 360;
   localparam int PHASE_COUNT  = 4;
   localparam int STALL_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 16;

   // One aligned block as it appears on the response channel
   typedef struct {
      logic [FIELD_W-1:0]  start;
      logic [PREFIX_W-1:0] prefix;
      logic                last;
   } block_type;

   // --------------------------------------------------------------------------
   // Block scoreboard: splits each accepted range and matches the blocks
   // --------------------------------------------------------------------------
   class block_scoreboard;
      block_type expected_blocks[$];
      int        mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Split the accepted range into aligned blocks, oldest first
      function void note_range(logic [FIELD_W-1:0] range_start,
                               logic [FIELD_W-1:0] range_length);
         logic [63:0] addr_mask;
         logic [63:0] base;
         logic [63:0] left;
         int          align_pow;
         int          size_pow;
         int          pow;
         int          n;
         block_type   blk;
         addr_mask = (64'd1 << ADDR_W) - 64'd1;
         base      = 64'(range_start) & addr_mask;
         left      = 64'(range_length) & addr_mask;
         n         = 0;
         while (left != 0 && n < MAX_BLOCKS) begin
            // alignment of the start; zero counts as fully aligned
            align_pow = ADDR_W;
            for (int i = ADDR_W - 1; i >= 0; i--) begin
               if (base[i]) align_pow = i;
            end
            // largest power of two not above what is left
            size_pow = 0;
            for (int i = 0; i < 64; i++) begin
               if (left[i]) size_pow = i;
            end
            pow        = (size_pow < align_pow) ? size_pow : align_pow;
            blk.start  = base[FIELD_W-1:0];
            blk.prefix = PREFIX_W'(ADDR_W - pow);
            left       = left - (64'd1 << pow);
            blk.last   = (left == 0) || (n == MAX_BLOCKS - 1);
            base       = (base + (64'd1 << pow)) & addr_mask;
            expected_blocks.push_back(blk);
            n++;
         end
      endfunction

      // Compare one block transfer with the oldest expected block
      function void check_block(logic [FIELD_W-1:0]  block_start,
                                logic [PREFIX_W-1:0] prefix_length,
                                logic                is_last);
         block_type want;
         if (expected_blocks.size() == 0) begin
            $error("unexpected block: block_start=%h prefix_length=%0d is_last=%b",
                   block_start, prefix_length, is_last);
            mismatches++;
            return;
         end
         want = expected_blocks.pop_front();
         if (block_start !== want.start) begin
            $error("block_start: expected %h, got %h", want.start, block_start);
            mismatches++;
         end
         if (prefix_length !== want.prefix) begin
            $error("prefix_length: expected %0d, got %0d", want.prefix, prefix_length);
            mismatches++;
         end
         if (is_last !== want.last) begin
            $error("is_last: expected %b, got %b", want.last, is_last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_blocks.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   apr_req_if req_ch ();
   apr_rsp_if rsp_ch ();

   block_scoreboard split_sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   aligned_pow2_range_splitter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: check each block transfer, then pick ready for next cycle
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            split_sb.check_block(rsp_ch.block_start, rsp_ch.prefix_length,
                                 rsp_ch.is_last);
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: cycles in a row with no transfer on either channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Send one range; valid stays high into the next range unless an idle
   // cycle is drawn
   task automatic send_range(input logic [FIELD_W-1:0] range_start,
                             input logic [FIELD_W-1:0] range_length);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.range_start  <= range_start;
      req_ch.range_length <= range_length;
      do @(posedge clock); while (!req_ch.ready);
      split_sb.note_range(range_start, range_length);
   endtask

   // Hold off the request side until every expected block has arrived;
   // valid drops before the wait, so it is not driven twice in one step
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (split_sb.pending() != 0) @(posedge clock);
   endtask

   // Start address: fully random, aligned to a random power, zero or near top
   function automatic logic [FIELD_W-1:0] random_start();
      logic [FIELD_W-1:0] addr;
      addr = $urandom;
      case ($urandom_range(9))
         0:       addr = '0;
         1:       addr = ~FIELD_W'($urandom_range(255));
         2, 3, 4: addr = addr & ({FIELD_W{1'b1}} << $urandom_range(FIELD_W - 1));
         default: ;
      endcase
      return addr;
   endfunction

   // Length: mostly spread over every magnitude, some short, few zero
   function automatic logic [FIELD_W-1:0] random_length();
      logic [FIELD_W-1:0] len;
      len = $urandom;
      case ($urandom_range(19))
         0:          len = '0;
         1:          len = '1;
         2, 3, 4, 5: len = FIELD_W'($urandom_range(64, 1));
         6, 7:       len = FIELD_W'(1) << $urandom_range(FIELD_W - 1);
         8, 9, 10:   ;
         default:    len = len >> $urandom_range(FIELD_W - 1);
      endcase
      return len;
   endfunction

   // Stimulus
   initial begin
      req_ch.valid        = 1'b0;
      req_ch.range_start  = '0;
      req_ch.range_length = '0;
      reset               = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed corners, no idling
      send_range(32'h0000_0000, 32'h0000_0000);   // zero length
      send_range(32'h1234_5678, 32'h0000_0000);   // zero length, busy start
      send_range(32'h0000_0000, 32'h0000_0001);   // zero start, one byte
      send_range(32'h0000_0000, 32'hFFFF_FFFF);   // zero start, full length
      send_range(32'h0000_0000, 32'h8000_0000);   // zero start, one huge block
      send_range(32'hFFFF_FFFF, 32'h0000_0001);   // top address
      send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // wraps almost all the way
      send_range(32'h0000_0001, 32'hFFFF_FFFF);   // climbing alignment
      send_range(32'h0000_0001, 32'hFFFF_FFFE);   // climb then descend
      send_range(32'h8000_0000, 32'h8000_0000);   // ends exactly at wrap
      send_range(32'hFFFF_FFF0, 32'h0000_0020);   // crosses the wrap
      send_range(32'h0000_1000, 32'h0000_1000);   // single aligned block
      send_range(32'h0000_0003, 32'h0000_000D);
      send_range(32'h5555_5555, 32'hAAAA_AAAA);
      send_range(32'hAAAA_AAAA, 32'h5555_5555);
      send_range(32'h7FFF_FFFF, 32'h8000_0001);
      send_range(32'hFFFF_FFFE, 32'h0000_0003);
      wait_drained();

      // random ranges under each idle pattern, draining between phases
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         for (int k = 0; k < RANDOM_RANGES / PHASE_COUNT; k++)
            send_range(random_start(), random_length());
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (split_sb.pending() != 0) begin
         $error("%0d expected blocks never arrived", split_sb.pending());
         split_sb.mismatches++;
      end
      if (split_sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
src/apr_pkg.sv
src/apr_if.sv
src/apr_front.sv
src/apr_queue.sv
src/apr_engine.sv
src/aligned_pow2_range_splitter.sv
dv/tb.sv
